// ===== src/bdth_pkg.sv =====
// Shared types and constants for the button debouncer with toggle and long-press hold.
// Used by the top level and by its port checker; depends on nothing else.

package bdth_pkg;

  // Width of the saturating hold counter (legal range 8 to 32).
  localparam int unsigned COUNT_WIDTH = 16;
  // Width of the press counter, which wraps.
  localparam int unsigned PRESS_WIDTH = 8;
  // Width of the tick thresholds held in configuration.
  localparam int unsigned TICK_WIDTH  = 16;
  // Width used to compare the hold counter with a threshold.
  localparam int unsigned CMP_WIDTH   = (COUNT_WIDTH > TICK_WIDTH) ? COUNT_WIDTH : TICK_WIDTH;

  // Press count at which a press is taken as steady.
  localparam logic [PRESS_WIDTH-1:0] STEADY_COUNT = PRESS_WIDTH'(3);

  // Reset values of the configuration registers.
  localparam logic                  ACTIVE_LOW_RST = 1'b0;
  localparam logic [TICK_WIDTH-1:0] MIN_PRESS_RST  = TICK_WIDTH'(40);
  localparam logic [TICK_WIDTH-1:0] MAX_PRESS_RST  = TICK_WIDTH'(400);

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_WIDTH = 2;
  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_ACTIVE_LOW = 2'd0,
    CFG_MIN_PRESS  = 2'd1,
    CFG_MAX_PRESS  = 2'd2
  } cfg_reg_e;

  // Bit positions in the event mask.
  localparam int unsigned EV_MOMENTARY = 0;
  localparam int unsigned EV_TOGGLE    = 1;
  localparam int unsigned EV_HOLD      = 2;
  localparam int unsigned EV_ERROR     = 3;
  localparam int unsigned EV_WIDTH     = 4;

  // Widths of the packed stream payloads.
  localparam int unsigned IN_DATA_WIDTH  = 8;
  localparam int unsigned OUT_DATA_WIDTH = 8;

  // One result item, last field in the lowest bits.
  typedef struct packed {
    logic [EV_WIDTH-1:0] event_mask;
    logic                error_hold;
    logic                hold;
    logic                toggle;
    logic                momentary;
  } result_t;

endpackage

// ===== src/button_debounce_toggle_hold.sv =====
// Top level of the button debouncer with toggle, long-press hold and stuck-button error.
// Depends on bdth_pkg for widths, register indexes and the result layout.
//
// Usage: every transaction on the slave stream is one periodic sample tick of the
// button pin, with the pin level in bit 0 of s_axis_tdata_i. For each tick the block
// returns exactly one result transaction on the master stream carrying the momentary,
// toggle, hold and error_hold flags and a mask of the events raised by that tick.
// The configuration channel (cfg_valid_i, cfg_index_i, cfg_data_i) writes the pin
// polarity and the two tick thresholds; it is always ready, and writes to an unused
// index are dropped. Configuration is meant to be written only while the block is idle.
//
// Timing: the whole update of one tick is a single pass of short logic (two increments
// and three compares) between the button state registers and the result register, so
// a result appears in the cycle after its tick is accepted, and one tick is taken in
// every clock cycle while each result is taken. The result register is the only
// storage between the two sides. When the receiver stalls, the result register holds
// its transaction and the slave side is ready again as soon as that result is taken;
// a tick and the taking of the previous result may happen in the same cycle.
//
// Reset (rst_ni low, asynchronous) returns the configuration to active-high polarity
// with thresholds of 40 and 400 ticks, clears the counters and flags, marks the button
// as at its default state, and empties the result register.

module button_debounce_toggle_hold
  import bdth_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Sample ticks. tdata: [0] pin_level, [7:1] zero.
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [IN_DATA_WIDTH-1:0]  s_axis_tdata_i,
  // Results. tdata: [0] momentary, [1] toggle, [2] hold, [3] error_hold,
  // [7:4] event_mask.
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  output logic [OUT_DATA_WIDTH-1:0] m_axis_tdata_o,
  // Configuration writes.
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CFG_IDX_WIDTH-1:0]  cfg_index_i,
  input  logic [TICK_WIDTH-1:0]     cfg_data_i
);

  // Configuration registers.
  logic                  active_low_q;
  logic [TICK_WIDTH-1:0] min_press_q;
  logic [TICK_WIDTH-1:0] max_press_q;

  // Button state.
  logic [PRESS_WIDTH-1:0] press_count_q, press_count_d;
  logic [COUNT_WIDTH-1:0] hold_count_q, hold_count_d;
  logic                   was_pressed_q, was_pressed_d;
  logic                   at_default_q, at_default_d;
  logic                   momentary_q, momentary_d;
  logic                   toggle_q, toggle_d;
  logic                   hold_q, hold_d;
  logic                   error_q, error_d;

  // Result register.
  logic    out_valid_q;
  result_t out_data_q;
  result_t result_d;

  logic                   in_fire;
  logic                   pressed;
  logic [PRESS_WIDTH-1:0] press_inc;
  logic [COUNT_WIDTH-1:0] hold_inc;
  logic [CMP_WIDTH-1:0]   hold_cmp;
  logic [EV_WIDTH-1:0]    events;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // Configuration writes; an index outside the register list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_low_q <= ACTIVE_LOW_RST;
      min_press_q  <= MIN_PRESS_RST;
      max_press_q  <= MAX_PRESS_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_ACTIVE_LOW: active_low_q <= cfg_data_i[0];
        CFG_MIN_PRESS:  min_press_q  <= cfg_data_i;
        CFG_MAX_PRESS:  max_press_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign pressed   = s_axis_tdata_i[0] ^ active_low_q;
  assign press_inc = press_count_q + PRESS_WIDTH'(1);
  // The hold counter saturates at all ones.
  assign hold_inc  = (&hold_count_q) ? hold_count_q : hold_count_q + COUNT_WIDTH'(1);
  assign hold_cmp  = CMP_WIDTH'(hold_inc);

  // Next state for one tick.
  always_comb begin
    press_count_d = press_count_q;
    hold_count_d  = hold_count_q;
    was_pressed_d = was_pressed_q;
    at_default_d  = at_default_q;
    momentary_d   = momentary_q;
    toggle_d      = toggle_q;
    hold_d        = hold_q;
    error_d       = error_q;
    events        = '0;

    if (!pressed) begin
      // Release clears the counters, momentary and error but keeps toggle and hold; at default the counters are kept.
      if (!at_default_q) begin
        press_count_d = '0;
        hold_count_d  = '0;
        momentary_d   = 1'b0;
        was_pressed_d = 1'b1;
        error_d       = 1'b0;
        at_default_d  = 1'b1;
      end
    end else begin
      press_count_d = press_inc;
      hold_count_d  = hold_inc;
      if (hold_cmp >= CMP_WIDTH'(max_press_q)) begin
        // Stuck button: clear the flags and raise an error on every such tick.
        press_count_d    = '0;
        momentary_d      = 1'b0;
        was_pressed_d    = 1'b1;
        error_d          = 1'b1;
        toggle_d         = 1'b0;
        hold_d           = 1'b0;
        events[EV_ERROR] = 1'b1;
      end else if (press_inc == STEADY_COUNT && !error_q) begin
        if (hold_cmp >= CMP_WIDTH'(min_press_q)) begin
          // Long press flips the hold flag once.
          if (!was_pressed_q) begin
            hold_d          = !hold_q;
            events[EV_HOLD] = 1'b1;
          end
          was_pressed_d = 1'b1;
        end else begin
          // Short steady press flips the toggle flag and sets momentary.
          if (was_pressed_q) begin
            toggle_d          = !toggle_q;
            events[EV_TOGGLE] = 1'b1;
          end
          if (!momentary_q) begin
            momentary_d          = 1'b1;
            events[EV_MOMENTARY] = 1'b1;
          end
          was_pressed_d = 1'b0;
          at_default_d  = 1'b0;
        end
      end
    end

    result_d.momentary  = momentary_d;
    result_d.toggle     = toggle_d;
    result_d.hold       = hold_d;
    result_d.error_hold = error_d;
    result_d.event_mask = events;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_count_q <= '0;
      hold_count_q  <= '0;
      was_pressed_q <= 1'b1;
      at_default_q  <= 1'b1;
      momentary_q   <= 1'b0;
      toggle_q      <= 1'b0;
      hold_q        <= 1'b0;
      error_q       <= 1'b0;
    end else if (in_fire) begin
      press_count_q <= press_count_d;
      hold_count_q  <= hold_count_d;
      was_pressed_q <= was_pressed_d;
      at_default_q  <= at_default_d;
      momentary_q   <= momentary_d;
      toggle_q      <= toggle_d;
      hold_q        <= hold_d;
      error_q       <= error_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= result_d;
    end
  end

endmodule

// ===== src/bdth_checker.sv =====
// Port-level checker for button_debounce_toggle_hold, attached by the bind below.
// Depends on bdth_pkg for widths and the event bit positions.

module bdth_checker
  import bdth_pkg::*;
(
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tready_o,
  input logic                      m_axis_tvalid_o,
  input logic                      m_axis_tready_i,
  input logic [OUT_DATA_WIDTH-1:0] m_axis_tdata_o
);

  result_t res;
  assign res = result_t'(m_axis_tdata_o);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  // With no result pending the block must take a tick.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("not ready with an empty result register");

  // An error event leaves only the error flag set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && res.event_mask[EV_ERROR] |->
      res.error_hold && !res.momentary && !res.toggle && !res.hold &&
      res.event_mask == EV_WIDTH'(1 << EV_ERROR))
    else $error("error event with inconsistent flags");

  // A toggle event always comes with the momentary flag set and no error or hold event.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && res.event_mask[EV_TOGGLE] |->
      res.momentary && !res.error_hold && !res.event_mask[EV_HOLD])
    else $error("toggle event with inconsistent flags");

  // A hold event never happens while in error-hold.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && res.event_mask[EV_HOLD] |->
      !res.error_hold && !res.event_mask[EV_MOMENTARY])
    else $error("hold event with inconsistent flags");

endmodule

bind button_debounce_toggle_hold bdth_checker u_bdth_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
